// ----- sv/bsfd_pkg.sv -----
// bsfd_pkg: shared constants, codes and types of the byte-stuffed frame deframer
// no dependencies; imported by bsfd_ctrl, bsfd_dp, the top level, bsfd_chk and the bench
`default_nettype none

package bsfd_pkg;

	localparam int RAW_DEPTH = 64;
	localparam int ADDR_W    = $clog2(RAW_DEPTH);
	localparam int CNT_W     = $clog2(RAW_DEPTH + 1);
	localparam int PADDR_W   = 4;

	// result status codes
	localparam logic [2:0] STAT_BUSY    = 3'd0;
	localparam logic [2:0] STAT_READY   = 3'd1;
	localparam logic [2:0] STAT_LEN_ERR = 3'd2;
	localparam logic [2:0] STAT_SUM_ERR = 3'd3;
	localparam logic [2:0] STAT_OVFL    = 3'd4;

	// register indexes (paddr[3:2])
	localparam logic [1:0] REG_DELIM = 2'd0;
	localparam logic [1:0] REG_ESC   = 2'd1;
	localparam logic [1:0] REG_MASK  = 2'd2;

	localparam logic [7:0] DELIM_RST = 8'h7E;
	localparam logic [7:0] ESC_RST   = 8'h7D;
	localparam logic [7:0] MASK_RST  = 8'h20;

	typedef struct packed {
		logic [7:0] delim;
		logic [7:0] esc;
		logic [7:0] mask;
	} bsfd_cfg_t;

	typedef struct packed {
		logic accept;
		logic rd;
		logic load_pay;
	} bsfd_cmd_t;

	typedef struct packed {
		logic start_drain;
		logic drain_last;
		logic out_free;
	} bsfd_sts_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] payload_byte;
		logic       payload_valid;
		logic [6:0] payload_length;
		logic       last;
	} bsfd_res_t;

endpackage

`default_nettype wire

// ----- sv/bsfd_rx_if.sv -----
// bsfd_rx_if: input channel, one received line byte per beat
// depends on nothing
`default_nettype none

interface bsfd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ----- sv/bsfd_res_if.sv -----
// bsfd_res_if: result channel, one status or payload result per beat
// depends on nothing
`default_nettype none

interface bsfd_res_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [7:0] payload_byte;
	logic       payload_valid;
	logic [6:0] payload_length;
	logic       last;

	modport source (output valid, output status, output payload_byte, output payload_valid,
		output payload_length, output last, input ready);
	modport sink   (input valid, input status, input payload_byte, input payload_valid,
		input payload_length, input last, output ready);
endinterface

`default_nettype wire

// ----- sv/bsfd_ram.sv -----
// bsfd_ram: generic single-write, single-read RAM with registered read data
// depends on nothing
`default_nettype none

module bsfd_ram #(
	parameter int W     = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [W-1:0]             wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [W-1:0]             rd_data
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- sv/bsfd_ctrl.sv -----
// bsfd_ctrl: controller, accepts line bytes and sequences the payload drain
// depends on bsfd_pkg
`default_nettype none

module bsfd_ctrl
	import bsfd_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire bsfd_sts_t sts,
	output bsfd_cmd_t      cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RD   = 2'd1;
	localparam logic [1:0] S_OUT  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		in_ready     = (state_q == S_IDLE) && sts.out_free;
		cmd.accept   = in_valid && in_ready;
		cmd.rd       = (state_q == S_RD);
		cmd.load_pay = (state_q == S_OUT) && sts.out_free;
		state_d      = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.accept && sts.start_drain) begin
					state_d = S_RD;
				end
			end
			S_RD: begin
				state_d = S_OUT;
			end
			S_OUT: begin
				if (cmd.load_pay) begin
					state_d = sts.drain_last ? S_IDLE : S_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ----- sv/bsfd_dp.sv -----
// bsfd_dp: datapath, unstuffing, body store, frame checks and result register
// depends on bsfd_pkg and bsfd_ram
`default_nettype none

module bsfd_dp
	import bsfd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire bsfd_cfg_t  cfg,
	input  wire logic [7:0] rx_byte,
	input  wire bsfd_cmd_t  cmd,
	output bsfd_sts_t       sts,
	output logic            out_valid,
	input  wire logic       out_ready,
	output bsfd_res_t       res
);

	logic              synced_q;
	logic              esc_q;
	logic [CNT_W-1:0]  count_q;
	logic [7:0]        len_q;
	logic [7:0]        xor_q;
	logic [CNT_W-1:0]  plen_q;
	logic [ADDR_W-1:0] idx_q;
	logic              out_valid_q;
	bsfd_res_t         res_q;

	logic             set_sync;
	logic             set_esc;
	logic             clr_body;
	logic             store_en;
	logic             do_write;
	logic [7:0]       store_val;
	logic [2:0]       single_status;
	logic             start_drain;
	logic             full;
	logic [CNT_W-1:0] plen;
	logic [7:0]       ram_q;

	assign full = (count_q >= CNT_W'(RAW_DEPTH));
	assign plen = count_q - CNT_W'(2);

	always_comb begin
		set_sync      = 1'b0;
		set_esc       = 1'b0;
		clr_body      = 1'b0;
		store_en      = 1'b0;
		store_val     = rx_byte;
		single_status = STAT_BUSY;
		start_drain   = 1'b0;
		if (!synced_q) begin
			if (rx_byte == cfg.delim) begin
				set_sync = 1'b1;
				clr_body = 1'b1;
			end
		end else if (esc_q) begin
			store_en  = 1'b1;
			store_val = rx_byte ^ cfg.mask;
		end else if (rx_byte == cfg.esc) begin
			set_esc = 1'b1;
		end else if (rx_byte == cfg.delim) begin
			clr_body = 1'b1;
			if (count_q < CNT_W'(2)) begin
				single_status = STAT_LEN_ERR;
			end else if (len_q != 8'(plen)) begin
				single_status = STAT_LEN_ERR;
			end else if (xor_q != 8'd0) begin
				single_status = STAT_SUM_ERR;
			end else if (plen == '0) begin
				single_status = STAT_READY;
			end else begin
				start_drain = 1'b1;
			end
		end else begin
			store_en = 1'b1;
		end
		do_write = store_en && !full;
		if (store_en && full) begin
			clr_body      = 1'b1;
			single_status = STAT_OVFL;
		end
	end

	assign sts.start_drain = start_drain;
	assign sts.drain_last  = (CNT_W'(idx_q) == plen_q);
	assign sts.out_free    = !out_valid_q || out_ready;

	bsfd_ram #(
		.W     (8),
		.DEPTH (RAW_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (cmd.accept && do_write),
		.wr_addr (count_q[ADDR_W-1:0]),
		.wr_data (store_val),
		.rd_en   (cmd.rd),
		.rd_addr (idx_q),
		.rd_data (ram_q)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			synced_q    <= 1'b0;
			esc_q       <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				if (set_sync) begin
					synced_q <= 1'b1;
				end
				esc_q <= set_esc;
				if (clr_body) begin
					count_q <= '0;
				end else if (do_write) begin
					count_q <= count_q + CNT_W'(1);
				end
			end
			if ((cmd.accept && !start_drain) || cmd.load_pay) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept && do_write) begin
			if (count_q == '0) begin
				len_q <= store_val;
				xor_q <= 8'd0;
			end else begin
				xor_q <= xor_q ^ store_val;
			end
		end
		if (cmd.accept && start_drain) begin
			plen_q <= plen;
			idx_q  <= ADDR_W'(1);
		end else if (cmd.load_pay) begin
			idx_q <= idx_q + ADDR_W'(1);
		end
		if (cmd.accept && !start_drain) begin
			res_q.status         <= single_status;
			res_q.payload_byte   <= 8'd0;
			res_q.payload_valid  <= 1'b0;
			res_q.payload_length <= 7'd0;
			res_q.last           <= 1'b1;
		end else if (cmd.load_pay) begin
			res_q.status         <= STAT_READY;
			res_q.payload_byte   <= ram_q;
			res_q.payload_valid  <= 1'b1;
			res_q.payload_length <= 7'(plen_q);
			res_q.last           <= sts.drain_last;
		end
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

// ----- sv/byte_stuffed_frame_deframer_unit.sv -----
// Byte-stuffed frame deframer with XOR checksum. A line byte that causes a single result
// (stored byte, escape, byte before sync, error or empty frame) loads it into the output
// register as the byte is taken, and a new byte is taken every cycle while results are taken.
// A closing delimiter of a good frame with n payload bytes gives n payload results, each
// through a registered read of the body RAM, then the output register; no byte is taken until the last is loaded.
// Depends on bsfd_pkg, bsfd_rx_if, bsfd_res_if, bsfd_ctrl, bsfd_dp.
`default_nettype none

module byte_stuffed_frame_deframer_unit
	import bsfd_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	bsfd_rx_if.sink                 rx,
	bsfd_res_if.source              result,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready
);

	bsfd_cfg_t  cfg_q;
	bsfd_cmd_t  cmd;
	bsfd_sts_t  sts;
	bsfd_res_t  res;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delim <= DELIM_RST;
			cfg_q.esc   <= ESC_RST;
			cfg_q.mask  <= MASK_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				REG_DELIM: cfg_q.delim <= pwdata[7:0];
				REG_ESC:   cfg_q.esc   <= pwdata[7:0];
				REG_MASK:  cfg_q.mask  <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_DELIM: prdata = {24'd0, cfg_q.delim};
			REG_ESC:   prdata = {24'd0, cfg_q.esc};
			REG_MASK:  prdata = {24'd0, cfg_q.mask};
			default:   prdata = 32'd0;
		endcase
	end

	bsfd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rx.valid),
		.in_ready (rx.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bsfd_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.rx_byte   (rx.rx_byte),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.res       (res)
	);

	assign result.status         = res.status;
	assign result.payload_byte   = res.payload_byte;
	assign result.payload_valid  = res.payload_valid;
	assign result.payload_length = res.payload_length;
	assign result.last           = res.last;

endmodule

`default_nettype wire

// ----- sv/bsfd_chk.sv -----
// bsfd_chk: port-level assertions for the deframer, bound to the top level
// depends on bsfd_pkg and byte_stuffed_frame_deframer_unit
`default_nettype none

module bsfd_chk
	import bsfd_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       rx_ready,
	input wire logic       res_valid,
	input wire logic       res_ready,
	input wire logic [2:0] status,
	input wire logic [7:0] payload_byte,
	input wire logic       payload_valid,
	input wire logic [6:0] payload_length,
	input wire logic       last
);

	// stalled beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(status) && $stable(payload_byte)
		&& $stable(last))
		else $error("result beat changed while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && payload_valid |-> status == STAT_READY && payload_length != 7'd0)
		else $error("payload beat without frame ready status");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !payload_valid |-> last && payload_byte == 8'd0
		&& payload_length == 7'd0)
		else $error("status beat carries payload fields");

	// no new line byte while a frame drains
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !last |-> !rx_ready)
		else $error("input taken during payload drain");

endmodule

bind byte_stuffed_frame_deframer_unit bsfd_chk u_bsfd_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.rx_ready       (rx.ready),
	.res_valid      (result.valid),
	.res_ready      (result.ready),
	.status         (result.status),
	.payload_byte   (result.payload_byte),
	.payload_valid  (result.payload_valid),
	.payload_length (result.payload_length),
	.last           (result.last)
);

`default_nettype wire

// ----- bench/tb.sv -----
// tb: self-checking bench for byte_stuffed_frame_deframer_unit, directed table then random frames
// depends on bsfd_pkg, bsfd_rx_if, bsfd_res_if and the deframer rtl
`timescale 1ns / 1ps

module tb;
	import bsfd_pkg::*;

	typedef struct packed {
		logic [7:0] b;
		logic       pin;
		logic [2:0] st;
	} line_row_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	bsfd_rx_if  rx_ch();
	bsfd_res_if res_ch();

	byte_stuffed_frame_deframer_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx_ch),
		.result  (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	logic [7:0] cfg_delim;
	logic [7:0] cfg_esc;
	logic [7:0] cfg_mask;
	logic       line_synced;
	logic       esc_armed;
	int         body_len;
	logic [7:0] body_bytes [RAW_DEPTH];

	bsfd_res_t step_results [$];
	bsfd_res_t due_results [$];

	int send_idle_pct;
	int recv_stall_pct;
	int bytes_sent;
	int beats_checked;
	int frames_delivered;
	int stat_seen [8];
	int mismatches;

	// flag, escape before sync, empty and short bodies, escaped flag and escape, bad length/sum
	line_row_t directed_rows [26] = '{
		'{8'h00, 1'b1, STAT_BUSY},    '{8'h7D, 1'b1, STAT_BUSY},
		'{8'hFF, 1'b1, STAT_BUSY},    '{8'h7E, 1'b1, STAT_BUSY},
		'{8'h7E, 1'b1, STAT_LEN_ERR}, '{8'h00, 1'b1, STAT_BUSY},
		'{8'h00, 1'b1, STAT_BUSY},    '{8'h7E, 1'b1, STAT_READY},
		'{8'h03, 1'b1, STAT_BUSY},    '{8'hFF, 1'b1, STAT_BUSY},
		'{8'h7D, 1'b1, STAT_BUSY},    '{8'h5E, 1'b1, STAT_BUSY},
		'{8'h7D, 1'b1, STAT_BUSY},    '{8'h5D, 1'b1, STAT_BUSY},
		'{8'hFC, 1'b1, STAT_BUSY},    '{8'h7E, 1'b0, STAT_READY},
		'{8'h05, 1'b1, STAT_BUSY},    '{8'h00, 1'b1, STAT_BUSY},
		'{8'h00, 1'b1, STAT_BUSY},    '{8'h7E, 1'b1, STAT_LEN_ERR},
		'{8'h01, 1'b1, STAT_BUSY},    '{8'h0A, 1'b1, STAT_BUSY},
		'{8'h0B, 1'b1, STAT_BUSY},    '{8'h7E, 1'b1, STAT_SUM_ERR},
		'{8'h01, 1'b1, STAT_BUSY},    '{8'h7E, 1'b1, STAT_LEN_ERR}
	};

	initial begin
		clk = 1'b0;
	end

	always #6 clk = ~clk;

	function automatic bsfd_res_t status_only(input logic [2:0] st);
		bsfd_res_t r;
		r = '0;
		r.status = st;
		r.last = 1'b1;
		return r;
	endfunction

	function automatic void keep_body_byte(input logic [7:0] v);
		if (body_len >= RAW_DEPTH) begin
			body_len = 0;
			esc_armed = 1'b0;
			step_results.push_back(status_only(STAT_OVFL));
		end else begin
			body_bytes[body_len] = v;
			body_len++;
			step_results.push_back(status_only(STAT_BUSY));
		end
	endfunction

	function automatic void predict_line_byte(input logic [7:0] b);
		int n;
		int i;
		logic [7:0] sum;
		bsfd_res_t r;
		step_results.delete();
		if (!line_synced) begin
			if (b == cfg_delim) begin
				line_synced = 1'b1;
				esc_armed = 1'b0;
				body_len = 0;
			end
			step_results.push_back(status_only(STAT_BUSY));
		end else if (esc_armed) begin
			esc_armed = 1'b0;
			keep_body_byte(b ^ cfg_mask);
		end else if (b == cfg_esc) begin
			esc_armed = 1'b1;
			step_results.push_back(status_only(STAT_BUSY));
		end else if (b == cfg_delim) begin
			n = body_len;
			body_len = 0;
			esc_armed = 1'b0;
			if (n < 2 || int'(body_bytes[0]) != n - 2) begin
				step_results.push_back(status_only(STAT_LEN_ERR));
			end else begin
				sum = '0;
				for (i = 1; i < n - 1; i++)
					sum ^= body_bytes[i];
				if (sum != body_bytes[n-1]) begin
					step_results.push_back(status_only(STAT_SUM_ERR));
				end else if (n == 2) begin
					step_results.push_back(status_only(STAT_READY));
				end else begin
					for (i = 0; i < n - 2; i++) begin
						r.status = STAT_READY;
						r.payload_byte = body_bytes[1+i];
						r.payload_valid = 1'b1;
						r.payload_length = 7'(n - 2);
						r.last = (i == n - 3);
						step_results.push_back(r);
					end
				end
			end
		end else begin
			keep_body_byte(b);
		end
	endfunction

	task automatic send_line_byte(input logic [7:0] b, input logic pin, input logic [2:0] st);
		if ($urandom_range(99) < send_idle_pct) begin
			rx_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.rx_byte <= b;
		do @(posedge clk); while (!rx_ch.ready);
		predict_line_byte(b);
		if (pin)
			due_results.push_back(status_only(st));
		else
			foreach (step_results[k]) due_results.push_back(step_results[k]);
		bytes_sent++;
	endtask

	task automatic cfg_read_check(input logic [1:0] idx);
		logic [7:0] want;
		case (idx)
			REG_DELIM: want = cfg_delim;
			REG_ESC:   want = cfg_esc;
			default:   want = cfg_mask;
		endcase
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== {24'd0, want}) begin
			$display("%0t: register %0d readback, expected %02h actual %08h",
				$realtime, idx, want, prdata);
			mismatches++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [7:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {24'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_DELIM: cfg_delim = val;
			REG_ESC:   cfg_esc = val;
			default:   cfg_mask = val;
		endcase
		cfg_read_check(idx);
	endtask

	task automatic wait_drained();
		rx_ch.valid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic send_body_byte(input logic [7:0] v);
		if (v == cfg_delim || v == cfg_esc || $urandom_range(15) == 0) begin
			send_line_byte(cfg_esc, 1'b0, STAT_BUSY);
			send_line_byte(v ^ cfg_mask, 1'b0, STAT_BUSY);
		end else begin
			send_line_byte(v, 1'b0, STAT_BUSY);
		end
	endtask

	task automatic send_frame();
		int kind;
		int plen;
		int cut;
		int i;
		logic [7:0] body [$];
		logic [7:0] v;
		logic [7:0] sum;
		kind = $urandom_range(99);
		if (kind < 10) begin
			repeat ($urandom_range(1, 6))
				send_line_byte(8'($urandom_range(255)), 1'b0, STAT_BUSY);
		end else begin
			if (kind < 14)
				plen = 62;
			else if (kind < 18)
				plen = 63 + $urandom_range(3);
			else if (kind < 35)
				plen = $urandom_range(0, 24);
			else
				plen = $urandom_range(0, 8);
			body.push_back(8'(plen));
			sum = '0;
			for (i = 0; i < plen; i++) begin
				case ($urandom_range(15))
					0:       v = cfg_delim;
					1:       v = cfg_esc;
					default: v = 8'($urandom_range(255));
				endcase
				body.push_back(v);
				sum ^= v;
			end
			body.push_back(sum);
			case ($urandom_range(9))
				0: body[0] = body[0] ^ 8'($urandom_range(1, 255));
				1: body[body.size()-1] = body[body.size()-1] ^ 8'($urandom_range(1, 255));
				2: begin
					cut = $urandom_range(1);
					while (body.size() > cut) void'(body.pop_back());
				end
				default: ;
			endcase
			foreach (body[k]) send_body_byte(body[k]);
			send_line_byte(cfg_delim, 1'b0, STAT_BUSY);
		end
	endtask

	task automatic run_phase(input logic [7:0] delim, input logic [7:0] esc,
		input logic [7:0] mask, input int send_pct, input int recv_pct, input int items);
		int start;
		wait_drained();
		cfg_write(REG_DELIM, delim);
		cfg_write(REG_ESC, esc);
		cfg_write(REG_MASK, mask);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		start = bytes_sent;
		while (bytes_sent - start < items) send_frame();
	endtask

	always @(posedge clk) begin : result_check
		bsfd_res_t got;
		bsfd_res_t want;
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				got = {res_ch.status, res_ch.payload_byte, res_ch.payload_valid,
					res_ch.payload_length, res_ch.last};
				if (due_results.size() == 0) begin
					$display("%0t: unexpected result beat, actual status %0d byte %02h",
						$realtime, got.status, got.payload_byte);
					mismatches++;
				end else begin
					want = due_results.pop_front();
					if (got !== want) begin
						$display({"%0t: result mismatch, expected status %0d byte %02h ",
							"valid %0d len %0d last %0d, actual status %0d byte %02h ",
							"valid %0d len %0d last %0d"}, $realtime,
							want.status, want.payload_byte, want.payload_valid,
							want.payload_length, want.last, got.status, got.payload_byte,
							got.payload_valid, got.payload_length, got.last);
						mismatches++;
					end
					beats_checked++;
					stat_seen[got.status]++;
					if (got.status == STAT_READY && got.last)
						frames_delivered++;
				end
			end
			res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin
		#20000000;
		$display("byte_stuffed_frame_deframer_unit: mismatch");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		rx_ch.valid = 1'b0;
		rx_ch.rx_byte = '0;
		res_ch.ready = 1'b0;
		cfg_delim = DELIM_RST;
		cfg_esc = ESC_RST;
		cfg_mask = MASK_RST;
		line_synced = 1'b0;
		esc_armed = 1'b0;
		body_len = 0;
		send_idle_pct = 20;
		recv_stall_pct = 57;
		bytes_sent = 0;
		beats_checked = 0;
		frames_delivered = 0;
		mismatches = 0;
		foreach (stat_seen[k]) stat_seen[k] = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		cfg_read_check(REG_DELIM);
		cfg_read_check(REG_ESC);
		cfg_read_check(REG_MASK);
		foreach (directed_rows[k])
			send_line_byte(directed_rows[k].b, directed_rows[k].pin, directed_rows[k].st);
		run_phase(DELIM_RST, ESC_RST, MASK_RST, 20, 57, 80);
		run_phase(8'h00, 8'hFF, 8'hFF, 20, 57, 60);
		run_phase(8'hFF, 8'h00, 8'h00, 57, 20, 60);
		// escape equal to flag
		run_phase(8'h55, 8'h55, 8'h01, 57, 20, 20);
		run_phase(8'h3C, 8'hC3, 8'($urandom_range(255)), 0, 0, 70);
		wait_drained();
		repeat (30) @(posedge clk);
		$display("%0d line bytes sent, %0d result beats checked, %0d frames delivered",
			bytes_sent, beats_checked, frames_delivered);
		$display("error beats: %0d length, %0d checksum, %0d overflow",
			stat_seen[STAT_LEN_ERR], stat_seen[STAT_SUM_ERR], stat_seen[STAT_OVFL]);
		if (mismatches == 0)
			$display("byte_stuffed_frame_deframer_unit: match");
		else
			$display("byte_stuffed_frame_deframer_unit: mismatch");
		$finish;
	end

endmodule
